[rtl/core/gsv_pkg.sv]
`timescale 1ns / 1ps
package gsv_pkg;

    localparam int MAX_COMPONENTS = 8;
    localparam int COMPONENT_BITS = 4;
    localparam int MAX_ENTRIES    = 4096;
    localparam int BASIS_BITS     = 16;

    localparam int VEC_W    = MAX_COMPONENTS * COMPONENT_BITS;
    localparam int RANK_W   = $clog2(MAX_ENTRIES);
    localparam int TOTAL_W  = RANK_W + 1;
    localparam int DEG_W    = 7;
    localparam int DEG_SLOTS = 2 ** DEG_W;
    localparam int LEN_W    = 4;
    localparam int CIDX_W   = $clog2(MAX_COMPONENTS);
    localparam int OP_W     = 4;
    localparam int STATUS_W = 3;
    localparam int CFG_IDX_W = 1;

    localparam logic [CFG_IDX_W-1:0] REG_TARGET_VECTOR = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TARGET_LENGTH = 1'b1;

    localparam logic [OP_W-1:0] OP_BUILD        = 4'd0;
    localparam logic [OP_W-1:0] OP_TYPE_TO_RANK = 4'd1;
    localparam logic [OP_W-1:0] OP_RANK_TO_TYPE = 4'd2;
    localparam logic [OP_W-1:0] OP_SUBTRACT     = 4'd3;
    localparam logic [OP_W-1:0] OP_IS_SUBTYPE   = 4'd4;
    localparam logic [OP_W-1:0] OP_FIRST_DEGREE = 4'd5;
    localparam logic [OP_W-1:0] OP_NEXT_DEGREE  = 4'd6;
    localparam logic [OP_W-1:0] OP_SET_BASIS    = 4'd7;
    localparam logic [OP_W-1:0] OP_GET_BASIS    = 4'd8;

    localparam logic [STATUS_W-1:0] STS_OK        = 3'd0;
    localparam logic [STATUS_W-1:0] STS_NONE      = 3'd1;
    localparam logic [STATUS_W-1:0] STS_NOT_BUILT = 3'd2;
    localparam logic [STATUS_W-1:0] STS_OVERFLOW  = 3'd3;
    localparam logic [STATUS_W-1:0] STS_RANGE     = 3'd4;

    typedef enum logic [2:0] {
        DISP_DONE,
        DISP_BUILD_BAD,
        DISP_POS,
        DISP_READ,
        DISP_BUILD
    } disp_t;

    typedef enum logic [2:0] {
        RES_DISP,
        RES_EVAL,
        RES_ROP,
        RES_OVER,
        RES_BUILD_OK
    } res_sel_t;

    typedef struct packed {
        logic     capture;
        logic     set_res;
        res_sel_t res_sel;
        logic     pos_init;
        logic     pos_step;
        logic     basis_wr;
        logic     b_init;
        logic     b_prod_step;
        logic     b_weight_step;
        logic     b_pass_step;
        logic     b_done;
    } cmd_t;

    typedef struct packed {
        disp_t disp;
        logic  eval_pos;
        logic  pos_done;
        logic  prod_over;
        logic  prod_last;
        logic  weight_last;
        logic  pass_last;
        logic  out_free;
    } sts_t;

    function automatic logic [COMPONENT_BITS-1:0] digit(
        input logic [VEC_W-1:0]  v,
        input logic [CIDX_W-1:0] i
    );
        return v[i*COMPONENT_BITS +: COMPONENT_BITS];
    endfunction

    function automatic logic [DEG_W-1:0] vec_degree(
        input logic [VEC_W-1:0] v,
        input logic [LEN_W-1:0] len
    );
        logic [DEG_W-1:0] sum;
        sum = '0;
        for (int i = 0; i < MAX_COMPONENTS; i++) begin
            if (LEN_W'(i) < len) begin
                sum = sum + DEG_W'(v[i*COMPONENT_BITS +: COMPONENT_BITS]);
            end
        end
        return sum;
    endfunction

endpackage

[rtl/core/gsv_ram.sv]
`timescale 1ns / 1ps
module gsv_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[rtl/core/gsv_ctrl.sv]
`timescale 1ns / 1ps
module gsv_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_valid,
    output logic          s_ready,
    input  gsv_pkg::sts_t sts,
    output gsv_pkg::cmd_t cmd
);
    import gsv_pkg::*;

    typedef enum logic [8:0] {
        ST_IDLE     = 9'b000000001,
        ST_DISP     = 9'b000000010,
        ST_EVAL     = 9'b000000100,
        ST_POS      = 9'b000001000,
        ST_ROP      = 9'b000010000,
        ST_B_PROD   = 9'b000100000,
        ST_B_WEIGHT = 9'b001000000,
        ST_B_PASS   = 9'b010000000,
        ST_B_FIN    = 9'b100000000
    } state_t;

    state_t state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        cmd.res_sel = RES_DISP;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next  = ST_DISP;
                end
            end
            ST_DISP: begin
                unique case (sts.disp)
                    DISP_DONE: begin
                        if (sts.out_free) begin
                            cmd.set_res = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end
                    DISP_BUILD_BAD: begin
                        cmd.b_init = 1'b1;
                        if (sts.out_free) begin
                            cmd.set_res = 1'b1;
                            state_next  = ST_IDLE;
                        end
                    end
                    DISP_POS: begin
                        cmd.pos_init = 1'b1;
                        state_next   = ST_POS;
                    end
                    DISP_READ: begin
                        state_next = ST_EVAL;
                    end
                    DISP_BUILD: begin
                        cmd.b_init = 1'b1;
                        state_next = ST_B_PROD;
                    end
                    default: begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            ST_EVAL: begin
                if (sts.eval_pos) begin
                    cmd.pos_init = 1'b1;
                    state_next   = ST_POS;
                end else if (sts.out_free) begin
                    cmd.set_res  = 1'b1;
                    cmd.res_sel  = RES_EVAL;
                    cmd.basis_wr = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_POS: begin
                if (sts.pos_done) begin
                    state_next = ST_ROP;
                end else begin
                    cmd.pos_step = 1'b1;
                end
            end
            ST_ROP: begin
                cmd.res_sel = RES_ROP;
                if (sts.out_free) begin
                    cmd.set_res = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            ST_B_PROD: begin
                cmd.res_sel = RES_OVER;
                if (sts.prod_over) begin
                    if (sts.out_free) begin
                        cmd.set_res = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end else begin
                    cmd.b_prod_step = 1'b1;
                    if (sts.prod_last) begin
                        state_next = ST_B_WEIGHT;
                    end
                end
            end
            ST_B_WEIGHT: begin
                cmd.b_weight_step = 1'b1;
                if (sts.weight_last) begin
                    state_next = ST_B_PASS;
                end
            end
            ST_B_PASS: begin
                cmd.b_pass_step = 1'b1;
                if (sts.pass_last) begin
                    state_next = ST_B_FIN;
                end
            end
            ST_B_FIN: begin
                cmd.res_sel = RES_BUILD_OK;
                if (sts.out_free) begin
                    cmd.set_res = 1'b1;
                    cmd.b_done  = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    a_set_needs_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.set_res |-> sts.out_free)
        else $error("result loaded into a busy output slot");

    a_pos_no_overrun: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.pos_step |-> !sts.pos_done)
        else $error("position step past last component");

    a_accept_dispatch: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> (state_reg == ST_DISP))
        else $error("accepted beat not dispatched");

endmodule

[rtl/core/gsv_datapath.sv]
`timescale 1ns / 1ps
module gsv_datapath (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    cfg_valid,
    output logic                                    cfg_ready,
    input  logic [gsv_pkg::CFG_IDX_W-1:0]           cfg_index,
    input  logic [gsv_pkg::VEC_W-1:0]               cfg_data,
    input  logic [gsv_pkg::OP_W-1:0]                s_operation,
    input  logic [gsv_pkg::VEC_W-1:0]               s_type_vec,
    input  logic [gsv_pkg::RANK_W-1:0]              s_rank_a,
    input  logic [gsv_pkg::RANK_W-1:0]              s_rank_b,
    input  logic [gsv_pkg::DEG_W-1:0]               s_degree_in,
    input  logic [gsv_pkg::BASIS_BITS-1:0]          s_basis_first_in,
    input  logic [gsv_pkg::BASIS_BITS-1:0]          s_basis_last_in,
    input  gsv_pkg::cmd_t                           cmd,
    output gsv_pkg::sts_t                           sts,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [gsv_pkg::STATUS_W-1:0]            m_status,
    output logic [gsv_pkg::RANK_W-1:0]              m_rank_out,
    output logic [gsv_pkg::VEC_W-1:0]               m_type_out,
    output logic [gsv_pkg::DEG_W-1:0]               m_degree_out,
    output logic                                    m_is_sub,
    output logic [gsv_pkg::BASIS_BITS-1:0]          m_basis_first_out,
    output logic [gsv_pkg::BASIS_BITS-1:0]          m_basis_last_out,
    output logic [gsv_pkg::TOTAL_W-1:0]             m_total_out
);
    import gsv_pkg::*;

    localparam int PW = TOTAL_W + COMPONENT_BITS + 1;
    localparam int MW = TOTAL_W + COMPONENT_BITS;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [RANK_W-1:0]     rank;
        logic [VEC_W-1:0]      vec;
        logic [DEG_W-1:0]      degree;
        logic                  is_sub;
        logic [BASIS_BITS-1:0] bfirst;
        logic [BASIS_BITS-1:0] blast;
        logic [TOTAL_W-1:0]    total;
    } res_t;

    // captured beat
    logic [OP_W-1:0]       op_reg;
    logic [VEC_W-1:0]      tv_reg;
    logic [RANK_W-1:0]     ra_reg, rb_reg;
    logic [DEG_W-1:0]      dg_reg;
    logic [BASIS_BITS-1:0] bf_reg, bl_reg;

    logic [VEC_W-1:0]      tvec_reg;
    logic [LEN_W-1:0]      tlen_reg;

    logic                  built_reg;
    logic [TOTAL_W-1:0]    total_reg;
    logic [DEG_W-1:0]      top_reg;
    logic [LEN_W-1:0]      blen_reg;
    logic [VEC_W-1:0]      lim_reg;
    logic [TOTAL_W-1:0]    weight_reg [MAX_COMPONENTS];

    logic [VEC_W-1:0]      pos_vec_reg;
    logic [TOTAL_W-1:0]    pos_acc_reg;
    logic [LEN_W-1:0]      pos_idx_reg;

    logic [TOTAL_W-1:0]    prod_reg;
    logic [CIDX_W-1:0]     bidx_reg;
    logic [TOTAL_W-1:0]    wacc_reg;
    logic [DEG_W-1:0]      pdeg_reg;
    logic [RANK_W-1:0]     p_reg;
    logic [VEC_W-1:0]      digits_reg;
    logic [TOTAL_W-1:0]    rank_reg;
    logic                  first_reg;

    logic                  m_valid_reg;
    res_t                  m_res_reg;

    logic [RANK_W-1:0]     rop_rdata;
    logic [VEC_W-1:0]      vor_a_rdata, vor_b_rdata;
    logic [TOTAL_W-1:0]    ds_rdata;
    logic [BASIS_BITS-1:0] bf_rdata, bl_rdata;

    logic                  len_bad, digit_bad, range_bad, neg, sub_ok;
    logic [VEC_W-1:0]      diff;
    logic [DEG_W-1:0]      deg_a, deg_b, deg_pos, cur_deg;
    logic [TOTAL_W-1:0]    next_rank;
    disp_t                 disp_sel;
    logic [STATUS_W-1:0]   disp_status;
    logic                  disp_zero_total;
    logic [LEN_W-1:0]      blen_m1;
    logic [COMPONENT_BITS:0] lim_b_plus;
    logic [PW-1:0]         prod_ext, wacc_ext;
    logic [MW-1:0]         pos_prod;
    logic                  pass_match, end_pass;
    logic [VEC_W-1:0]      digits_inc;
    res_t                  res;

    logic                  basis_we;
    logic [RANK_W-1:0]     basis_waddr;
    logic [BASIS_BITS-1:0] basis_wfirst, basis_wlast;
    logic                  vec_we;
    logic [RANK_W-1:0]     vor_b_raddr;

    function automatic logic [VEC_W-1:0] odometer(
        input logic [VEC_W-1:0] d,
        input logic [VEC_W-1:0] lim,
        input logic [LEN_W-1:0] len
    );
        logic [VEC_W-1:0] v;
        logic             carry;
        int               i;
        v     = d;
        carry = 1'b1;
        for (int k = 0; k < MAX_COMPONENTS; k++) begin
            i = MAX_COMPONENTS - 1 - k;
            if (LEN_W'(i) < len && carry) begin
                if (v[i*COMPONENT_BITS +: COMPONENT_BITS] ==
                    lim[i*COMPONENT_BITS +: COMPONENT_BITS]) begin
                    v[i*COMPONENT_BITS +: COMPONENT_BITS] = '0;
                end else begin
                    v[i*COMPONENT_BITS +: COMPONENT_BITS] =
                        v[i*COMPONENT_BITS +: COMPONENT_BITS] + COMPONENT_BITS'(1);
                    carry = 1'b0;
                end
            end
        end
        return v;
    endfunction

    assign cfg_ready = 1'b1;

    // query checks
    always_comb begin
        digit_bad = 1'b0;
        neg       = 1'b0;
        sub_ok    = 1'b1;
        diff      = '0;
        for (int i = 0; i < MAX_COMPONENTS; i++) begin
            if (LEN_W'(i) < blen_reg) begin
                if (digit(tv_reg, CIDX_W'(i)) > digit(lim_reg, CIDX_W'(i))) begin
                    digit_bad = 1'b1;
                end
                if (digit(vor_b_rdata, CIDX_W'(i)) > digit(vor_a_rdata, CIDX_W'(i))) begin
                    neg = 1'b1;
                end
                if (digit(vor_a_rdata, CIDX_W'(i)) > digit(vor_b_rdata, CIDX_W'(i))) begin
                    sub_ok = 1'b0;
                end
                diff[i*COMPONENT_BITS +: COMPONENT_BITS] =
                    digit(vor_a_rdata, CIDX_W'(i)) - digit(vor_b_rdata, CIDX_W'(i));
            end
        end
    end

    assign len_bad   = (tlen_reg == '0) || (tlen_reg > LEN_W'(MAX_COMPONENTS));
    assign range_bad = ({1'b0, ra_reg} >= total_reg) ||
                       (((op_reg == OP_SUBTRACT) || (op_reg == OP_IS_SUBTYPE)) &&
                        ({1'b0, rb_reg} >= total_reg));
    assign deg_a     = vec_degree(vor_a_rdata, blen_reg);
    assign deg_b     = vec_degree(vor_b_rdata, blen_reg);
    assign deg_pos   = vec_degree(pos_vec_reg, blen_reg);
    assign next_rank = {1'b0, ra_reg} + TOTAL_W'(1);

    // dispatch decision
    always_comb begin
        disp_sel        = DISP_DONE;
        disp_status     = STS_RANGE;
        disp_zero_total = 1'b0;
        if (op_reg == OP_BUILD) begin
            disp_zero_total = 1'b1;
            disp_sel        = len_bad ? DISP_BUILD_BAD : DISP_BUILD;
        end else if (op_reg > OP_GET_BASIS) begin
            disp_zero_total = 1'b1;
        end else if (!built_reg) begin
            disp_status     = STS_NOT_BUILT;
            disp_zero_total = 1'b1;
        end else if (op_reg == OP_TYPE_TO_RANK) begin
            if (!digit_bad) begin
                disp_sel = DISP_POS;
            end
        end else if (op_reg == OP_FIRST_DEGREE) begin
            if (dg_reg > top_reg) begin
                disp_status = STS_NONE;
            end else begin
                disp_sel = DISP_READ;
            end
        end else if (!range_bad) begin
            disp_sel = DISP_READ;
        end
    end

    // build arithmetic
    assign blen_m1    = blen_reg - LEN_W'(1);
    assign lim_b_plus = {1'b0, digit(lim_reg, bidx_reg)} + (COMPONENT_BITS+1)'(1);
    assign prod_ext   = PW'(prod_reg) * PW'(lim_b_plus);
    assign wacc_ext   = PW'(wacc_reg) * PW'(lim_b_plus);
    assign pos_prod   = MW'(digit(pos_vec_reg, pos_idx_reg[CIDX_W-1:0])) *
                        MW'(weight_reg[pos_idx_reg[CIDX_W-1:0]]);
    assign cur_deg    = vec_degree(digits_reg, blen_reg);
    assign pass_match = (cur_deg == pdeg_reg);
    assign end_pass   = ({1'b0, p_reg} == total_reg - TOTAL_W'(1));
    assign digits_inc = odometer(digits_reg, lim_reg, blen_reg);

    assign sts.disp        = disp_sel;
    assign sts.eval_pos    = (op_reg == OP_SUBTRACT) && !neg;
    assign sts.pos_done    = (pos_idx_reg == blen_reg);
    assign sts.prod_over   = (prod_ext > PW'(MAX_ENTRIES));
    assign sts.prod_last   = ({1'b0, bidx_reg} == blen_m1);
    assign sts.weight_last = (bidx_reg == '0);
    assign sts.pass_last   = end_pass && (pdeg_reg == top_reg);
    assign sts.out_free    = !m_valid_reg || m_ready;

    // result selection
    always_comb begin
        res = '0;
        case (cmd.res_sel)
            RES_DISP: begin
                res.status = disp_status;
                res.total  = disp_zero_total ? '0 : total_reg;
            end
            RES_EVAL: begin
                res.total = total_reg;
                case (op_reg)
                    OP_RANK_TO_TYPE: begin
                        res.rank   = ra_reg;
                        res.vec    = vor_a_rdata;
                        res.degree = deg_a;
                    end
                    OP_SUBTRACT: begin
                        res.status = STS_RANGE;
                    end
                    OP_IS_SUBTYPE: begin
                        res.is_sub = sub_ok;
                    end
                    OP_FIRST_DEGREE: begin
                        res.rank = ds_rdata[RANK_W-1:0];
                    end
                    OP_NEXT_DEGREE: begin
                        if (next_rank >= total_reg || deg_b > deg_a) begin
                            res.status = STS_NONE;
                        end else begin
                            res.rank = next_rank[RANK_W-1:0];
                        end
                    end
                    OP_SET_BASIS: begin
                        res.rank   = ra_reg;
                        res.bfirst = bf_reg;
                        res.blast  = bl_reg;
                    end
                    OP_GET_BASIS: begin
                        res.rank   = ra_reg;
                        res.bfirst = bf_rdata;
                        res.blast  = bl_rdata;
                    end
                    default: begin
                        res.status = STS_RANGE;
                    end
                endcase
            end
            RES_ROP: begin
                res.total = total_reg;
                res.rank  = rop_rdata;
                if (op_reg == OP_SUBTRACT) begin
                    res.vec    = pos_vec_reg;
                    res.degree = deg_pos;
                end
            end
            RES_OVER: begin
                res.status = STS_OVERFLOW;
            end
            RES_BUILD_OK: begin
                res.degree = top_reg;
                res.total  = total_reg;
            end
            default: begin
                res.status = STS_RANGE;
            end
        endcase
    end

    // memory ports
    assign basis_we     = (cmd.b_pass_step && (pdeg_reg == '0)) ||
                          (cmd.basis_wr && (op_reg == OP_SET_BASIS));
    assign basis_waddr  = cmd.b_pass_step ? p_reg : ra_reg;
    assign basis_wfirst = cmd.b_pass_step ? '0 : bf_reg;
    assign basis_wlast  = cmd.b_pass_step ? '0 : bl_reg;
    assign vec_we       = cmd.b_pass_step && pass_match;
    assign vor_b_raddr  = (op_reg == OP_NEXT_DEGREE) ? next_rank[RANK_W-1:0] : rb_reg;

    gsv_ram #(.WIDTH(RANK_W), .DEPTH(MAX_ENTRIES)) u_rop (
        .aclk  (aclk),
        .we    (vec_we),
        .waddr (p_reg),
        .wdata (rank_reg[RANK_W-1:0]),
        .raddr (pos_acc_reg[RANK_W-1:0]),
        .rdata (rop_rdata)
    );

    gsv_ram #(.WIDTH(VEC_W), .DEPTH(MAX_ENTRIES)) u_vor_a (
        .aclk  (aclk),
        .we    (vec_we),
        .waddr (rank_reg[RANK_W-1:0]),
        .wdata (digits_reg),
        .raddr (ra_reg),
        .rdata (vor_a_rdata)
    );

    gsv_ram #(.WIDTH(VEC_W), .DEPTH(MAX_ENTRIES)) u_vor_b (
        .aclk  (aclk),
        .we    (vec_we),
        .waddr (rank_reg[RANK_W-1:0]),
        .wdata (digits_reg),
        .raddr (vor_b_raddr),
        .rdata (vor_b_rdata)
    );

    gsv_ram #(.WIDTH(TOTAL_W), .DEPTH(DEG_SLOTS)) u_dstart (
        .aclk  (aclk),
        .we    (cmd.b_pass_step && first_reg),
        .waddr (pdeg_reg),
        .wdata (rank_reg),
        .raddr (dg_reg),
        .rdata (ds_rdata)
    );

    gsv_ram #(.WIDTH(BASIS_BITS), .DEPTH(MAX_ENTRIES)) u_bfirst (
        .aclk  (aclk),
        .we    (basis_we),
        .waddr (basis_waddr),
        .wdata (basis_wfirst),
        .raddr (ra_reg),
        .rdata (bf_rdata)
    );

    gsv_ram #(.WIDTH(BASIS_BITS), .DEPTH(MAX_ENTRIES)) u_blast (
        .aclk  (aclk),
        .we    (basis_we),
        .waddr (basis_waddr),
        .wdata (basis_wlast),
        .raddr (ra_reg),
        .rdata (bl_rdata)
    );

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tvec_reg    <= '0;
            tlen_reg    <= LEN_W'(1);
            built_reg   <= 1'b0;
            total_reg   <= '0;
            top_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    REG_TARGET_VECTOR: tvec_reg <= cfg_data;
                    REG_TARGET_LENGTH: tlen_reg <= cfg_data[LEN_W-1:0];
                    default: ;
                endcase
            end
            if (cmd.b_init) begin
                built_reg <= 1'b0;
                total_reg <= '0;
                top_reg   <= '0;
            end
            if (cmd.b_weight_step && sts.weight_last) begin
                total_reg <= prod_reg;
                top_reg   <= vec_degree(lim_reg, blen_reg);
            end
            if (cmd.b_done) begin
                built_reg <= 1'b1;
            end
            if (cmd.set_res) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // payload and sequencing registers
    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg <= s_operation;
            tv_reg <= s_type_vec;
            ra_reg <= s_rank_a;
            rb_reg <= s_rank_b;
            dg_reg <= s_degree_in;
            bf_reg <= s_basis_first_in;
            bl_reg <= s_basis_last_in;
        end
        if (cmd.pos_init) begin
            pos_vec_reg <= (op_reg == OP_TYPE_TO_RANK) ? tv_reg : diff;
            pos_acc_reg <= '0;
            pos_idx_reg <= '0;
        end
        if (cmd.pos_step) begin
            pos_acc_reg <= pos_acc_reg + pos_prod[TOTAL_W-1:0];
            pos_idx_reg <= pos_idx_reg + LEN_W'(1);
        end
        if (cmd.b_init) begin
            lim_reg  <= tvec_reg;
            blen_reg <= tlen_reg;
            prod_reg <= TOTAL_W'(1);
            bidx_reg <= '0;
        end
        if (cmd.b_prod_step) begin
            prod_reg <= prod_ext[TOTAL_W-1:0];
            if (sts.prod_last) begin
                bidx_reg <= blen_m1[CIDX_W-1:0];
                wacc_reg <= TOTAL_W'(1);
            end else begin
                bidx_reg <= bidx_reg + CIDX_W'(1);
            end
        end
        if (cmd.b_weight_step) begin
            weight_reg[bidx_reg] <= wacc_reg;
            wacc_reg             <= wacc_ext[TOTAL_W-1:0];
            if (sts.weight_last) begin
                pdeg_reg   <= '0;
                p_reg      <= '0;
                digits_reg <= '0;
                rank_reg   <= '0;
                first_reg  <= 1'b1;
            end else begin
                bidx_reg <= bidx_reg - CIDX_W'(1);
            end
        end
        if (cmd.b_pass_step) begin
            if (pass_match) begin
                rank_reg <= rank_reg + TOTAL_W'(1);
            end
            if (end_pass) begin
                p_reg      <= '0;
                digits_reg <= '0;
                pdeg_reg   <= pdeg_reg + DEG_W'(1);
                first_reg  <= 1'b1;
            end else begin
                p_reg      <= p_reg + RANK_W'(1);
                digits_reg <= digits_inc;
                first_reg  <= 1'b0;
            end
        end
        if (cmd.set_res) begin
            m_res_reg <= res;
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_status          = m_res_reg.status;
    assign m_rank_out        = m_res_reg.rank;
    assign m_type_out        = m_res_reg.vec;
    assign m_degree_out      = m_res_reg.degree;
    assign m_is_sub          = m_res_reg.is_sub;
    assign m_basis_first_out = m_res_reg.bfirst;
    assign m_basis_last_out  = m_res_reg.blast;
    assign m_total_out       = m_res_reg.total;

    a_pass_rank_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.b_pass_step |-> (rank_reg < total_reg))
        else $error("rank counter ran past the entry count");

    a_no_basis_clash: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.b_pass_step && cmd.basis_wr))
        else $error("basis write during table fill");

endmodule

[rtl/core/graded_subvector_table_top.sv]
`timescale 1ns / 1ps
// Queries decided by their operands alone load the result from dispatch; those
// that read the tables go through the table-read state first. type_to_rank does
// the position multiply-add, one component per cycle, then reads the rank table;
// subtract reads the tables, then does the same if its difference is not negative.
// Build makes one pass over all positions per degree through the single write
// port of each table. One item at a time: the next beat is taken once the result
// sits in the output register. Reset clears control state; tables stay unwritten.
module graded_subvector_table_top (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [gsv_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [gsv_pkg::VEC_W-1:0]           cfg_data,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [gsv_pkg::OP_W-1:0]            s_operation,
    input  logic [gsv_pkg::VEC_W-1:0]           s_type_vec,
    input  logic [gsv_pkg::RANK_W-1:0]          s_rank_a,
    input  logic [gsv_pkg::RANK_W-1:0]          s_rank_b,
    input  logic [gsv_pkg::DEG_W-1:0]           s_degree_in,
    input  logic [gsv_pkg::BASIS_BITS-1:0]      s_basis_first_in,
    input  logic [gsv_pkg::BASIS_BITS-1:0]      s_basis_last_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic [gsv_pkg::STATUS_W-1:0]        m_status,
    output logic [gsv_pkg::RANK_W-1:0]          m_rank_out,
    output logic [gsv_pkg::VEC_W-1:0]           m_type_out,
    output logic [gsv_pkg::DEG_W-1:0]           m_degree_out,
    output logic                                m_is_sub,
    output logic [gsv_pkg::BASIS_BITS-1:0]      m_basis_first_out,
    output logic [gsv_pkg::BASIS_BITS-1:0]      m_basis_last_out,
    output logic [gsv_pkg::TOTAL_W-1:0]         m_total_out
);
    import gsv_pkg::*;

    cmd_t cmd;
    sts_t sts;

    gsv_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    gsv_datapath u_dp (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .s_operation       (s_operation),
        .s_type_vec        (s_type_vec),
        .s_rank_a          (s_rank_a),
        .s_rank_b          (s_rank_b),
        .s_degree_in       (s_degree_in),
        .s_basis_first_in  (s_basis_first_in),
        .s_basis_last_in   (s_basis_last_in),
        .cmd               (cmd),
        .sts               (sts),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_rank_out        (m_rank_out),
        .m_type_out        (m_type_out),
        .m_degree_out      (m_degree_out),
        .m_is_sub          (m_is_sub),
        .m_basis_first_out (m_basis_first_out),
        .m_basis_last_out  (m_basis_last_out),
        .m_total_out       (m_total_out)
    );

endmodule

[tb/sv/tb_graded_subvector_table_top.sv]
`timescale 1ns / 1ps
module tb_graded_subvector_table_top;
    import gsv_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]   status;
        logic [RANK_W-1:0]     rank;
        logic [VEC_W-1:0]      vec;
        logic [DEG_W-1:0]      degree;
        logic                  is_sub;
        logic [BASIS_BITS-1:0] bfirst;
        logic [BASIS_BITS-1:0] blast;
        logic [TOTAL_W-1:0]    total;
    } gsv_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [VEC_W-1:0] cfg_data = '0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic [OP_W-1:0] s_operation = '0;
    logic [VEC_W-1:0] s_type_vec = '0;
    logic [RANK_W-1:0] s_rank_a = '0;
    logic [RANK_W-1:0] s_rank_b = '0;
    logic [DEG_W-1:0] s_degree_in = '0;
    logic [BASIS_BITS-1:0] s_basis_first_in = '0;
    logic [BASIS_BITS-1:0] s_basis_last_in = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [STATUS_W-1:0] m_status;
    logic [RANK_W-1:0] m_rank_out;
    logic [VEC_W-1:0] m_type_out;
    logic [DEG_W-1:0] m_degree_out;
    logic m_is_sub;
    logic [BASIS_BITS-1:0] m_basis_first_out;
    logic [BASIS_BITS-1:0] m_basis_last_out;
    logic [TOTAL_W-1:0] m_total_out;

    graded_subvector_table_top uut (.*);

    // predictor state
    logic [VEC_W-1:0]      cur_target = '0;
    logic [LEN_W-1:0]      cur_length = 1;
    logic [RANK_W-1:0]     rank_at_pos [MAX_ENTRIES];
    logic [VEC_W-1:0]      vec_at_rank [MAX_ENTRIES];
    logic [TOTAL_W-1:0]    first_rank_of_deg [DEG_SLOTS];
    logic [BASIS_BITS-1:0] basis_lo [MAX_ENTRIES];
    logic [BASIS_BITS-1:0] basis_hi [MAX_ENTRIES];
    int                    limit_of [MAX_COMPONENTS];
    int                    weight_of [MAX_COMPONENTS];
    int                    used_len = 1;
    int                    entry_total = 0;
    int                    max_degree = 0;
    bit                    is_built = 0;

    gsv_result_t pending_results[$];
    int errors = 0;
    int idle_pct = 14;
    int cycles = 0;

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > 2000000) begin
            $display("Verification failed");
            $finish;
        end
    end

    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= idle_pct);
    end

    always @(posedge aclk) begin
        gsv_result_t got, want;
        if (aresetn && m_valid && m_ready) begin
            got = '{m_status, m_rank_out, m_type_out, m_degree_out, m_is_sub,
                    m_basis_first_out, m_basis_last_out, m_total_out};
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result %p", $realtime, got);
                errors++;
            end else begin
                want = pending_results.pop_front();
                if (got !== want) begin
                    $display("%0t: mismatch expected %p actual %p", $realtime, want, got);
                    errors++;
                end
            end
        end
    end

    function automatic int digit_at(input logic [VEC_W-1:0] v, input int i);
        return int'(v[i*COMPONENT_BITS +: COMPONENT_BITS]);
    endfunction

    function automatic int degree_sum(input logic [VEC_W-1:0] v);
        int d;
        d = 0;
        for (int i = 0; i < used_len; i++) d += digit_at(v, i);
        return d;
    endfunction

    function automatic logic [VEC_W-1:0] vec_from_pos(input int p);
        logic [VEC_W-1:0] v;
        int rem;
        v = '0;
        rem = p;
        for (int i = used_len - 1; i >= 0; i--) begin
            v[i*COMPONENT_BITS +: COMPONENT_BITS] = COMPONENT_BITS'(rem % (limit_of[i] + 1));
            rem = rem / (limit_of[i] + 1);
        end
        return v;
    endfunction

    function automatic int pos_of_vec(input logic [VEC_W-1:0] v);
        int p;
        p = 0;
        for (int i = 0; i < used_len; i++) p += digit_at(v, i) * weight_of[i];
        return p;
    endfunction

    task automatic rebuild_tables(output gsv_result_t r);
        int len, prod, fill [DEG_SLOTS];
        logic [VEC_W-1:0] v;
        r = '0;
        is_built = 0;
        entry_total = 0;
        max_degree = 0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            basis_lo[i] = '0;
            basis_hi[i] = '0;
        end
        len = int'(cur_length);
        if (len < 1 || len > MAX_COMPONENTS) begin
            r.status = STS_RANGE;
            return;
        end
        prod = 1;
        for (int i = 0; i < len; i++) begin
            limit_of[i] = digit_at(cur_target, i);
            prod *= limit_of[i] + 1;
            if (prod > MAX_ENTRIES) begin
                r.status = STS_OVERFLOW;
                return;
            end
        end
        used_len = len;
        weight_of[len-1] = 1;
        for (int i = len - 1; i > 0; i--) weight_of[i-1] = (limit_of[i] + 1) * weight_of[i];
        for (int i = 0; i < len; i++) max_degree += limit_of[i];
        entry_total = prod;
        for (int d = 0; d < DEG_SLOTS; d++) fill[d] = 0;
        for (int p = 0; p < prod; p++) fill[degree_sum(vec_from_pos(p)) + 1 < DEG_SLOTS ?
                                            degree_sum(vec_from_pos(p)) + 1 : 0]++;
        first_rank_of_deg[0] = '0;
        for (int d = 1; d < DEG_SLOTS; d++)
            first_rank_of_deg[d] = first_rank_of_deg[d-1] + TOTAL_W'(fill[d]);
        for (int d = 0; d < DEG_SLOTS; d++) fill[d] = int'(first_rank_of_deg[d]);
        for (int p = 0; p < prod; p++) begin
            v = vec_from_pos(p);
            rank_at_pos[p] = RANK_W'(fill[degree_sum(v)]);
            vec_at_rank[fill[degree_sum(v)]] = v;
            fill[degree_sum(v)]++;
        end
        is_built = 1;
        r.degree = DEG_W'(max_degree);
        r.total = TOTAL_W'(entry_total);
    endtask

    task automatic predict_table_op(
        input logic [OP_W-1:0] op, input logic [VEC_W-1:0] tv,
        input int ra, input int rb, input int dg,
        input logic [BASIS_BITS-1:0] bf, input logic [BASIS_BITS-1:0] bl,
        output gsv_result_t r
    );
        logic [VEC_W-1:0] va, vb, diff;
        r = '0;
        if (op == OP_BUILD) begin
            rebuild_tables(r);
            return;
        end
        if (op > OP_GET_BASIS) begin
            r.status = STS_RANGE;
            return;
        end
        if (!is_built) begin
            r.status = STS_NOT_BUILT;
            return;
        end
        r.total = TOTAL_W'(entry_total);
        if (op == OP_TYPE_TO_RANK) begin
            for (int i = 0; i < used_len; i++)
                if (digit_at(tv, i) > limit_of[i]) begin
                    r.status = STS_RANGE;
                    return;
                end
            r.rank = rank_at_pos[pos_of_vec(tv)];
            return;
        end
        if (op == OP_FIRST_DEGREE) begin
            if (dg > max_degree) r.status = STS_NONE;
            else r.rank = RANK_W'(first_rank_of_deg[dg]);
            return;
        end
        if (ra >= entry_total ||
            ((op == OP_SUBTRACT || op == OP_IS_SUBTYPE) && rb >= entry_total)) begin
            r.status = STS_RANGE;
            return;
        end
        va = vec_at_rank[ra];
        vb = vec_at_rank[rb < entry_total ? rb : 0];
        case (op)
            OP_RANK_TO_TYPE: begin
                r.rank = RANK_W'(ra);
                r.vec = va;
                r.degree = DEG_W'(degree_sum(va));
            end
            OP_SUBTRACT: begin
                diff = '0;
                for (int i = 0; i < used_len; i++) begin
                    if (digit_at(vb, i) > digit_at(va, i)) begin
                        r.status = STS_RANGE;
                        return;
                    end
                    diff[i*COMPONENT_BITS +: COMPONENT_BITS] =
                        COMPONENT_BITS'(digit_at(va, i) - digit_at(vb, i));
                end
                r.rank = rank_at_pos[pos_of_vec(diff)];
                r.vec = diff;
                r.degree = DEG_W'(degree_sum(diff));
            end
            OP_IS_SUBTYPE: begin
                r.is_sub = 1'b1;
                for (int i = 0; i < used_len; i++)
                    if (digit_at(va, i) > digit_at(vb, i)) r.is_sub = 1'b0;
            end
            OP_NEXT_DEGREE: begin
                if (ra + 1 >= entry_total ||
                    degree_sum(vec_at_rank[ra+1]) > degree_sum(va)) begin
                    r.status = STS_NONE;
                    r.total = TOTAL_W'(entry_total);
                end else begin
                    r.rank = RANK_W'(ra + 1);
                end
            end
            OP_SET_BASIS: begin
                basis_lo[ra] = bf;
                basis_hi[ra] = bl;
                r.rank = RANK_W'(ra);
                r.bfirst = bf;
                r.blast = bl;
            end
            default: begin
                r.rank = RANK_W'(ra);
                r.bfirst = basis_lo[ra];
                r.blast = basis_hi[ra];
            end
        endcase
    endtask

    task automatic send_item(
        input logic [OP_W-1:0] op, input logic [VEC_W-1:0] tv,
        input logic [RANK_W-1:0] ra, input logic [RANK_W-1:0] rb,
        input logic [DEG_W-1:0] dg,
        input logic [BASIS_BITS-1:0] bf, input logic [BASIS_BITS-1:0] bl
    );
        gsv_result_t r;
        if ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            do @(posedge aclk); while ($urandom_range(99) < idle_pct);
        end
        s_operation <= op;
        s_type_vec <= tv;
        s_rank_a <= ra;
        s_rank_b <= rb;
        s_degree_in <= dg;
        s_basis_first_in <= bf;
        s_basis_last_in <= bl;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        predict_table_op(op, tv, int'(ra), int'(rb), int'(dg), bf, bl, r);
        pending_results.push_back(r);
    endtask

    task automatic send_op(input logic [OP_W-1:0] op, input int ra = 0, input int rb = 0);
        send_item(op, $urandom, RANK_W'(ra), RANK_W'(rb), DEG_W'($urandom),
                  BASIS_BITS'($urandom), BASIS_BITS'($urandom));
    endtask

    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [VEC_W-1:0] val);
        cfg_index <= idx;
        cfg_data <= val;
        cfg_valid <= 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_TARGET_VECTOR) cur_target = val;
        else cur_length = val[LEN_W-1:0];
    endtask

    task automatic load_target(input logic [VEC_W-1:0] vec, input logic [VEC_W-1:0] len);
        drain_results();
        write_reg(REG_TARGET_VECTOR, vec);
        write_reg(REG_TARGET_LENGTH, len);
        cfg_valid <= 1'b0;
    endtask

    task automatic test_unbuilt();
        for (int op = 1; op <= 9; op++) send_op(OP_W'(op), $urandom, $urandom);
        send_op(4'hF);
    endtask

    task automatic test_bad_targets();
        load_target(32'h0000_0012, 0);
        send_op(OP_BUILD);
        send_op(OP_RANK_TO_TYPE);
        load_target(32'h0000_0012, 15);
        send_op(OP_BUILD);
        load_target(32'hFFFF_FFFF, 8);
        send_op(OP_BUILD);
        send_op(OP_GET_BASIS);
    endtask

    task automatic test_small_table();
        load_target(32'hFFFF_F312, 3);
        send_op(OP_BUILD);
        send_item(OP_TYPE_TO_RANK, 32'hABCD_E312, 0, 0, 0, 0, 0);
        send_item(OP_TYPE_TO_RANK, 32'h0000_0412, 0, 0, 0, 0, 0);
        send_op(OP_RANK_TO_TYPE, entry_total - 1);
        send_op(OP_RANK_TO_TYPE, entry_total);
        send_op(OP_SUBTRACT, entry_total - 1, 0);
        send_op(OP_SUBTRACT, 0, entry_total - 1);
        send_op(OP_IS_SUBTYPE, 1, entry_total - 1);
        send_item(OP_FIRST_DEGREE, 0, 0, 0, DEG_W'(max_degree), 0, 0);
        send_item(OP_FIRST_DEGREE, 0, 0, 0, DEG_W'(max_degree + 1), 0, 0);
        send_item(OP_FIRST_DEGREE, 0, 0, 0, 7'h7F, 0, 0);
        send_op(OP_NEXT_DEGREE, entry_total - 1);
        send_op(OP_NEXT_DEGREE, 0);
        send_item(OP_SET_BASIS, 0, 5, 0, 0, 16'hFFFF, 16'h0000);
        send_op(OP_GET_BASIS, 5);
        send_op(OP_GET_BASIS, 4095);
        send_op(4'd12);
    endtask

    task automatic test_largest_tables();
        load_target(32'h0000_0000, 1);
        send_op(OP_BUILD);
        send_op(OP_NEXT_DEGREE, 0);
        load_target(32'h1111_1111, 8);
        send_op(OP_BUILD);
        send_item(OP_TYPE_TO_RANK, 32'h1111_1111, 0, 0, 0, 0, 0);
        load_target(32'h0000_0FFF, 3);
        send_op(OP_BUILD);
        send_item(OP_TYPE_TO_RANK, 32'h0000_0FFF, 0, 0, 0, 0, 0);
        send_op(OP_SUBTRACT, 4095, 4095);
        send_item(OP_SET_BASIS, 0, 4095, 0, 0, 16'h0000, 16'hFFFF);
        send_op(OP_GET_BASIS, 4095);
    endtask

    function automatic int pick_rank();
        if (entry_total > 0 && $urandom_range(99) < 88) return $urandom_range(entry_total - 1);
        return $urandom_range(4095);
    endfunction

    function automatic logic [VEC_W-1:0] below_vec(input logic [VEC_W-1:0] v);
        logic [VEC_W-1:0] w;
        w = $urandom;
        for (int i = 0; i < used_len; i++)
            w[i*COMPONENT_BITS +: COMPONENT_BITS] = COMPONENT_BITS'($urandom_range(digit_at(v, i)));
        return w;
    endfunction

    function automatic logic [VEC_W-1:0] cur_target_limits();
        logic [VEC_W-1:0] v;
        v = '0;
        for (int i = 0; i < used_len; i++)
            v[i*COMPONENT_BITS +: COMPONENT_BITS] = COMPONENT_BITS'(limit_of[i]);
        return v;
    endfunction

    task automatic random_query();
        int op, ra, rb;
        logic [VEC_W-1:0] tv;
        op = $urandom_range(99) < 4 ? $urandom_range(15) : $urandom_range(1, 8);
        ra = pick_rank();
        rb = pick_rank();
        tv = $urandom;
        if (is_built && entry_total > 0) begin
            if (op == OP_TYPE_TO_RANK && $urandom_range(99) < 85)
                tv = below_vec(cur_target_limits());
            if ((op == OP_SUBTRACT || op == OP_IS_SUBTYPE) && ra < entry_total &&
                $urandom_range(99) < 60) begin
                rb = rank_at_pos[pos_of_vec(below_vec(vec_at_rank[ra]))];
                if (op == OP_IS_SUBTYPE) begin
                    int t;
                    t = ra;
                    ra = rb;
                    rb = t;
                end
            end
        end
        send_item(OP_W'(op), tv, RANK_W'(ra), RANK_W'(rb),
                  $urandom_range(99) < 80 ? DEG_W'($urandom_range(max_degree + 1)) :
                  DEG_W'($urandom), BASIS_BITS'($urandom), BASIS_BITS'($urandom));
    endtask

    task automatic test_random_tables();
        logic [VEC_W-1:0] vec;
        int len, sel;
        for (int phase = 0; phase < 24; phase++) begin
            idle_pct = (phase == 10 || phase == 11) ? 0 : 14;
            vec = $urandom;
            sel = $urandom_range(99);
            if (sel < 70) begin
                len = $urandom_range(1, 4);
                for (int i = 0; i < len; i++)
                    vec[i*COMPONENT_BITS +: COMPONENT_BITS] = COMPONENT_BITS'($urandom_range(3));
            end else if (sel < 88) begin
                len = $urandom_range(5, 8);
                for (int i = 0; i < len; i++)
                    vec[i*COMPONENT_BITS +: COMPONENT_BITS] = COMPONENT_BITS'($urandom_range(1));
            end else if (sel < 94) begin
                len = $urandom_range(1, 2);
                for (int i = 0; i < len; i++)
                    vec[i*COMPONENT_BITS +: COMPONENT_BITS] = COMPONENT_BITS'($urandom_range(15));
            end else begin
                len = $urandom_range(99) < 50 ? 0 : $urandom_range(9, 15);
            end
            load_target(vec, VEC_W'(len));
            send_op(OP_BUILD);
            for (int n = 0; n < 42; n++) random_query();
        end
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_unbuilt();
        test_bad_targets();
        test_small_table();
        test_largest_tables();
        test_random_tables();
        drain_results();
        repeat (20) @(posedge aclk);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end
endmodule
